// File: hdl/euclidean_distance_transform_3d_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the distance transform block
// Shared property wrappers, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_TRANSFORM_3D_TOP_MACROS_SVH
`define EUCLIDEAN_DISTANCE_TRANSFORM_3D_TOP_MACROS_SVH

// checked outside reset only
`define EDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define EDT_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/edt_pkg.sv
// ---------------------------------------------------------------------------
// Distance transform package
// Operation codes, register indexes, field widths and cell control.
// ---------------------------------------------------------------------------
package edt_pkg;

  localparam int VAL_W  = 13;
  localparam int DIST_W = 11;
  localparam int SIZE_W = 6;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_MARK  = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic clear;  // reset every running minimum
    logic shift;  // move minima one cell towards the head
  } ctl_t;

endpackage

// File: hdl/edt_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One read or write a cycle, registered read data.
// ---------------------------------------------------------------------------
module edt_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: hdl/edt_sqrt.sv
// ---------------------------------------------------------------------------
// Integer square root
// Floor square root of value * 256, two radicand bits a cycle.
// ---------------------------------------------------------------------------
module edt_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [edt_pkg::VAL_W-1:0]  value_i,
  output logic                       done_o,
  output logic [edt_pkg::DIST_W-1:0] root_o
);
  import edt_pkg::*;

  localparam int RAD_W = 2 * DIST_W;

  logic             run_q;
  logic [3:0]       cnt_q;
  logic [RAD_W-1:0] rad_q;
  logic [11:0]      rem_q;
  logic [DIST_W-1:0] root_q;
  logic             done_q;
  logic [13:0]      rem_w, trial, diff;
  logic             ge;

  assign rem_w = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign diff  = rem_w - trial;
  assign ge    = rem_w >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= {{(RAD_W - VAL_W - 8){1'b0}}, value_i, 8'd0};
        rem_q  <= '0;
        root_q <= '0;
      end else if (run_q) begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        rem_q  <= ge ? diff[11:0] : rem_w[11:0];
        root_q <= {root_q[DIST_W-2:0], ge};
        cnt_q  <= cnt_q + 4'd1;
        if (cnt_q == 4'(DIST_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: hdl/edt_cell.sv
// ---------------------------------------------------------------------------
// Line minimum cell
// Holds the running minimum of value plus squared offset for one line
// position; passes the line sample on to its neighbour every cycle.
// ---------------------------------------------------------------------------
module edt_cell #(
  parameter int IDX = 0,
  parameter int PW  = 11,
  parameter int SW  = 23
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  edt_pkg::ctl_t             ctl_i,
  input  logic                      tok_vld_i,
  input  logic                      tok_inf_i,
  input  logic [edt_pkg::VAL_W-1:0] tok_val_i,
  input  logic signed [PW-1:0]      tok_pos_i,
  output logic                      tok_vld_o,
  output logic                      tok_inf_o,
  output logic [edt_pkg::VAL_W-1:0] tok_val_o,
  output logic signed [PW-1:0]      tok_pos_o,
  input  logic [SW-1:0]             best_i,
  output logic [SW-1:0]             best_o
);
  import edt_pkg::*;

  logic signed [PW:0] diff;
  logic [PW-1:0]      mag;
  logic [2*PW-1:0]    sq;
  logic [SW-1:0]      cand;
  logic [SW-1:0]      best_q;

  assign diff = {tok_pos_i[PW-1], tok_pos_i} - (PW+1)'(IDX);
  assign mag  = diff[PW] ? PW'(-diff) : diff[PW-1:0];
  assign sq   = mag * mag;
  assign cand = {1'b0, sq} + SW'(tok_val_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_o <= 1'b0;
    end else begin
      tok_vld_o <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_inf_o <= tok_inf_i;
    tok_val_o <= tok_val_i;
    tok_pos_o <= tok_pos_i;
    if (ctl_i.clear) begin
      best_q <= '1;
    end else if (ctl_i.shift) begin
      best_q <= best_i;
    end else if (tok_vld_i && !tok_inf_i && cand < best_q) begin
      best_q <= cand;
    end
  end

  assign best_o = best_q;

endmodule

// File: hdl/euclidean_distance_transform_3d_top.sv
// ---------------------------------------------------------------------------
// 3D squared Euclidean distance transform
// Volume store in RAM, separable x/y/z passes through a chain of line cells.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             op_i, x_i, y_i, z_i
// result    out        done_o, one cycle         squared_distance_o, distance_o, status_o
// config    in         psel & penable & pwrite   paddr, pwdata (prdata on read)
//
// Mark: result in the cycle after accept. Read: RAM read, then the 11-step root.
// Clear: one RAM word a cycle over all MAX_X*MAX_Y*MAX_Z words; the same sweep runs
// after reset with busy high. Run: for each of the three passes and each line of
// length n, the line cells are cleared, the n samples are read in, the chain drains
// through all L cells (L = chain length, the largest MAX_) and n minima are written back.
// The result channel has no stall: a result stands for exactly one cycle.
// ---------------------------------------------------------------------------
module euclidean_distance_transform_3d_top #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op_i,
  input  logic [4:0]                 x_i,
  input  logic [4:0]                 y_i,
  input  logic [4:0]                 z_i,
  output logic                       done_o,
  output logic [edt_pkg::VAL_W-1:0]  squared_distance_o,
  output logic [edt_pkg::DIST_W-1:0] distance_o,
  output logic                       status_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import edt_pkg::*;

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int L     = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                         : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);
  localparam int CW    = $clog2(L + 1);
  localparam int PW    = CW + 2;
  localparam int SW    = 2 * PW + 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDWAIT, ST_SQRT, ST_LINE,
    ST_LOAD, ST_TAIL, ST_DRAIN, ST_UNLOAD, ST_NEXT
  } state_e;

  typedef enum logic [1:0] {PASS_X, PASS_Y, PASS_Z} pass_e;

  state_e           state_q;
  pass_e            pass_q;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [AW-1:0]    clr_q;
  logic             clr_resp_q;
  logic [CW-1:0]    e_q, i0_q, i1_q;
  logic             rd_pend_q;
  logic [CW-1:0]    rd_pos_q;
  logic             done_q, status_q;
  logic [VAL_W-1:0] sqd_q;
  logic [DIST_W-1:0] dist_q;

  logic             tok_vld_q, tok_inf_q;
  logic [VAL_W-1:0] tok_val_q;
  logic signed [PW-1:0] tok_pos_q;

  logic [CW-1:0]    nx, ny, nz, nline, lim0, lim1;
  logic [CW-1:0]    ca, cb, cc;
  logic             accept, in_box, cfg_wr;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic             sq_start, sq_done;
  logic [DIST_W-1:0] sq_root;

  ctl_t             ctl;

  logic                 tv [L+1];
  logic                 ti [L+1];
  logic [VAL_W-1:0]     tval [L+1];
  logic signed [PW-1:0] tpos [L+1];
  logic [SW-1:0]        bc [L+1];

  function automatic logic [CW-1:0] clamp_size(logic [SIZE_W-1:0] v, int mx);
    logic [CW-1:0] r;
    if (v == '0) r = CW'(1);
    else if (int'(v) > mx) r = CW'(mx);
    else r = CW'(v);
    return r;
  endfunction

  function automatic logic [AW-1:0] vox_addr(logic [CW-1:0] a, logic [CW-1:0] b,
                                              logic [CW-1:0] c);
    return AW'(int'(a) + MAX_X * (int'(b) + MAX_Y * int'(c)));
  endfunction

  assign nx = clamp_size(size_x_q, MAX_X);
  assign ny = clamp_size(size_y_q, MAX_Y);
  assign nz = clamp_size(size_z_q, MAX_Z);

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign in_box = (int'(x_i) < int'(nx)) && (int'(y_i) < int'(ny)) &&
                  (int'(z_i) < int'(nz));
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // line geometry for the current pass
  always_comb begin
    case (pass_q)
      PASS_X: begin
        nline = nx; lim0 = ny; lim1 = nz;
        ca = e_q; cb = i0_q; cc = i1_q;
      end
      PASS_Y: begin
        nline = ny; lim0 = nx; lim1 = nz;
        ca = i0_q; cb = e_q; cc = i1_q;
      end
      default: begin
        nline = nz; lim0 = nx; lim1 = ny;
        ca = i0_q; cb = i1_q; cc = e_q;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = vox_addr(ca, cb, cc);
    unique case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      ST_IDLE: begin
        ram_addr  = vox_addr(CW'(x_i), CW'(y_i), CW'(z_i));
        ram_we    = accept && (op_i == OP_MARK) && in_box;
        ram_wdata = VAL_W'(1);
      end
      ST_UNLOAD: begin
        ram_we    = 1'b1;
        ram_wdata = bc[0][VAL_W-1:0];
      end
      default: ;
    endcase
  end

  assign ctl.clear = (state_q == ST_LINE);
  assign ctl.shift = (state_q == ST_UNLOAD);
  assign sq_start  = (state_q == ST_RDWAIT);

  always_comb begin
    unique case (paddr[3:2])
      REG_SIZE_X: prdata = 32'(size_x_q);
      REG_SIZE_Y: prdata = 32'(size_y_q);
      REG_SIZE_Z: prdata = 32'(size_z_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      pass_q     <= PASS_X;
      clr_q      <= '0;
      clr_resp_q <= 1'b0;
      e_q        <= '0;
      i0_q       <= '0;
      i1_q       <= '0;
      rd_pend_q  <= 1'b0;
      tok_vld_q  <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= 1'b0;
      size_x_q   <= SIZE_W'(32);
      size_y_q   <= SIZE_W'(32);
      size_z_q   <= SIZE_W'(32);
    end else begin
      done_q    <= 1'b0;
      tok_vld_q <= 1'b0;
      rd_pend_q <= 1'b0;

      if (cfg_wr) begin
        case (paddr[3:2])
          REG_SIZE_X: size_x_q <= pwdata[SIZE_W-1:0];
          REG_SIZE_Y: size_y_q <= pwdata[SIZE_W-1:0];
          REG_SIZE_Z: size_z_q <= pwdata[SIZE_W-1:0];
          default: ;
        endcase
      end

      // feed the chain from the RAM read issued last cycle
      if (rd_pend_q) begin
        tok_vld_q <= 1'b1;
        tok_inf_q <= (pass_q == PASS_X) && (ram_rdata != '0);
        tok_val_q <= (pass_q == PASS_X) ? '0 : ram_rdata;
        tok_pos_q <= PW'(rd_pos_q);
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q    <= ST_IDLE;
            clr_resp_q <= 1'b0;
            if (clr_resp_q) begin
              done_q   <= 1'b1;
              status_q <= 1'b0;
              sqd_q    <= '0;
              dist_q   <= '0;
            end
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (op_e'(op_i))
              OP_CLEAR: begin
                state_q    <= ST_CLEAR;
                clr_q      <= '0;
                clr_resp_q <= 1'b1;
              end
              OP_RUN: begin
                state_q <= ST_LINE;
                pass_q  <= PASS_X;
                i0_q    <= '0;
                i1_q    <= '0;
              end
              OP_MARK: begin
                done_q   <= 1'b1;
                status_q <= !in_box;
                sqd_q    <= '0;
                dist_q   <= '0;
              end
              OP_READ: begin
                if (in_box) begin
                  state_q <= ST_RDWAIT;
                end else begin
                  done_q   <= 1'b1;
                  status_q <= 1'b1;
                  sqd_q    <= '0;
                  dist_q   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RDWAIT: begin
          sqd_q   <= ram_rdata;
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_done) begin
            done_q   <= 1'b1;
            status_q <= 1'b0;
            dist_q   <= sq_root;
            state_q  <= ST_IDLE;
          end
        end
        ST_LINE: begin
          // left boundary stands nx + 1 places before the line (nx: clamped size_x)
          if (pass_q == PASS_X) begin
            tok_vld_q <= 1'b1;
            tok_inf_q <= 1'b0;
            tok_val_q <= '0;
            tok_pos_q <= PW'(-(int'(nline) + 1));
          end
          e_q     <= '0;
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (e_q < nline) begin
            rd_pend_q <= 1'b1;
            rd_pos_q  <= e_q;
            e_q       <= e_q + CW'(1);
          end else begin
            state_q <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (pass_q == PASS_X) begin
            tok_vld_q <= 1'b1;
            tok_inf_q <= 1'b0;
            tok_val_q <= '0;
            tok_pos_q <= PW'(2 * int'(nline));
          end
          e_q     <= '0;
          state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          // let the last sample pass every cell
          e_q <= e_q + CW'(1);
          if (e_q == CW'(L)) begin
            e_q     <= '0;
            state_q <= ST_UNLOAD;
          end
        end
        ST_UNLOAD: begin
          e_q <= e_q + CW'(1);
          if (e_q == nline - CW'(1)) begin
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          state_q <= ST_LINE;
          if (i0_q + CW'(1) < lim0) begin
            i0_q <= i0_q + CW'(1);
          end else begin
            i0_q <= '0;
            if (i1_q + CW'(1) < lim1) begin
              i1_q <= i1_q + CW'(1);
            end else begin
              i1_q <= '0;
              case (pass_q)
                PASS_X:  pass_q <= PASS_Y;
                PASS_Y:  pass_q <= PASS_Z;
                default: begin
                  state_q  <= ST_IDLE;
                  done_q   <= 1'b1;
                  status_q <= 1'b0;
                  sqd_q    <= '0;
                  dist_q   <= '0;
                end
              endcase
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign squared_distance_o = sqd_q;
  assign distance_o         = dist_q;

  edt_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  edt_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .value_i(ram_rdata),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  assign tv[0]   = tok_vld_q;
  assign ti[0]   = tok_inf_q;
  assign tval[0] = tok_val_q;
  assign tpos[0] = tok_pos_q;
  assign bc[L]   = '1;

  for (genvar k = 0; k < L; k++) begin : g_cell
    edt_cell #(.IDX(k), .PW(PW), .SW(SW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .tok_vld_i(tv[k]),
      .tok_inf_i(ti[k]),
      .tok_val_i(tval[k]),
      .tok_pos_i(tpos[k]),
      .tok_vld_o(tv[k+1]),
      .tok_inf_o(ti[k+1]),
      .tok_val_o(tval[k+1]),
      .tok_pos_o(tpos[k+1]),
      .best_i   (bc[k+1]),
      .best_o   (bc[k])
    );
  end

endmodule

// File: hdl/edt_checker.sv
// ---------------------------------------------------------------------------
// Distance transform port checker
// Watches the top level ports for result consistency and mark latency.
// ---------------------------------------------------------------------------
`include "euclidean_distance_transform_3d_top_macros.svh"

module edt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 op_i,
  input logic                       done_o,
  input logic [edt_pkg::VAL_W-1:0]  squared_distance_o,
  input logic [edt_pkg::DIST_W-1:0] distance_o,
  input logic                       status_o
);
  import edt_pkg::*;

  logic [31:0] d2, d1sq, s256;

  assign d2   = 32'(distance_o) * 32'(distance_o);
  assign d1sq = (32'(distance_o) + 32'd1) * (32'(distance_o) + 32'd1);
  assign s256 = 32'(squared_distance_o) << 8;

  `EDT_ASSERT_ANY(a_err_zero, done_o && status_o |-> squared_distance_o == '0 && distance_o == '0, "rejected transaction carries data")
  `EDT_ASSERT(a_root_lo, done_o |-> d2 <= s256, "distance above root")
  `EDT_ASSERT(a_root_hi, done_o |-> d1sq > s256, "distance below root")
  `EDT_ASSERT(a_mark_lat, start && !busy && op_i == OP_MARK |=> done_o, "mark result late")

endmodule

bind euclidean_distance_transform_3d_top edt_checker u_edt_checker (.*);
